// ===== hw/rtl/dlns_pkg.sv =====
// Shared types, widths and helper functions for the data locality node selector.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.
package dlns_pkg;

  localparam int NUM_NODES_DEF = 16;
  localparam int DATA_BITS_DEF = 64;

  // Fixed port widths.
  localparam int MASK_W  = 16;
  localparam int COUNT_W = 5;
  localparam int JOB_W   = 64;
  localparam int NODE_W  = 4;
  localparam int SHARE_W = 7;

  // Result of one pass through the shared share unit.
  typedef struct packed {
    logic [SHARE_W-1:0] share;
    logic               better;
  } share_res_t;

  function automatic logic [SHARE_W-1:0] popcount(input logic [JOB_W-1:0] v);
    logic [SHARE_W-1:0] n;
    n = '0;
    for (int i = 0; i < JOB_W; i++) begin
      n = n + SHARE_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/data_locality_node_selector.sv =====
// A word is taken when start is high and busy is low; busy then stays high until the
// result is ready, and the result appears on the out_ ports for one cycle with out_valid,
// which cannot be held off. A request that fails, or asks for zero nodes, skips the scan
// and goes straight to the finish state, which registers its result. Any other request
// scans the nodes one per cycle through a single shared popcount and compare unit, over
// the first NUM_NODES nodes, capped at 16; a single-node request then passes through a
// write-back state that ORs the job's data into the chosen node's store before the
// finish state. A new word may be started in the same cycle as out_valid. The store is
// cleared by reset.
module data_locality_node_selector #(
  parameter int NUM_NODES = dlns_pkg::NUM_NODES_DEF,
  parameter int DATA_BITS = dlns_pkg::DATA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dlns_pkg::MASK_W-1:0]   in_available_mask,
  input  logic [dlns_pkg::COUNT_W-1:0]  in_requested_count,
  input  logic [dlns_pkg::JOB_W-1:0]    in_job_data,
  output logic                          out_valid,
  output logic                          out_fits,
  output logic [dlns_pkg::MASK_W-1:0]   out_allocated_mask,
  output logic [dlns_pkg::NODE_W-1:0]   out_chosen_node,
  output logic [dlns_pkg::SHARE_W-1:0]  out_best_share
);

  localparam int ACTIVE = (NUM_NODES < dlns_pkg::MASK_W) ? NUM_NODES : dlns_pkg::MASK_W;
  localparam int IDX_W  = $clog2(ACTIVE);
  localparam int CW     = dlns_pkg::COUNT_W;
  localparam int SW     = dlns_pkg::SHARE_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_WRITE  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [ACTIVE-1:0]    avail_r, avail_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [DATA_BITS-1:0] data_r, data_nxt;
  logic                 fits_r, fits_nxt;
  logic                 single_r, single_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [SW-1:0]        best_r, best_nxt;
  logic                 found_r, found_nxt;
  logic [ACTIVE-1:0]    alloc_r, alloc_nxt;
  logic [CW-1:0]        taken_r, taken_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_fits_r, out_fits_nxt;
  logic [dlns_pkg::MASK_W-1:0] out_alloc_r, out_alloc_nxt;
  logic [dlns_pkg::NODE_W-1:0] out_node_r, out_node_nxt;
  logic [SW-1:0]        out_share_r, out_share_nxt;

  logic [ACTIVE-1:0]    in_avail;
  logic [SW-1:0]        free_count;
  logic                 in_fail;
  logic                 accept;
  logic [DATA_BITS-1:0] node_word;
  logic                 wr_en;
  dlns_pkg::share_res_t share_res;

  assign accept     = start && (state_r == S_IDLE);
  assign in_avail   = in_available_mask[ACTIVE-1:0];
  assign free_count = dlns_pkg::popcount(dlns_pkg::JOB_W'(in_avail));
  assign in_fail    = SW'(in_requested_count) > free_count;
  assign wr_en      = (state_r == S_WRITE);

  dlns_node_store #(
    .NODES     (ACTIVE),
    .DATA_BITS (DATA_BITS),
    .IDX_W     (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_idx  (idx_r),
    .rd_data (node_word),
    .wr_en   (wr_en),
    .wr_idx  (pick_r),
    .wr_bits (data_r)
  );

  dlns_share_unit #(
    .DATA_BITS (DATA_BITS)
  ) u_share (
    .node_word (node_word),
    .job_word  (data_r),
    .best      (best_r),
    .found     (found_r),
    .res       (share_res)
  );

  always_comb begin
    state_nxt     = state_r;
    avail_nxt     = avail_r;
    count_nxt     = count_r;
    data_nxt      = data_r;
    fits_nxt      = fits_r;
    single_nxt    = single_r;
    idx_nxt       = idx_r;
    pick_nxt      = pick_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    alloc_nxt     = alloc_r;
    taken_nxt     = taken_r;
    out_valid_nxt = 1'b0;
    out_fits_nxt  = out_fits_r;
    out_alloc_nxt = out_alloc_r;
    out_node_nxt  = out_node_r;
    out_share_nxt = out_share_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          avail_nxt  = in_avail;
          count_nxt  = in_requested_count;
          data_nxt   = in_job_data[DATA_BITS-1:0];
          fits_nxt   = !in_fail;
          single_nxt = !in_fail && (in_requested_count == CW'(1));
          idx_nxt    = '0;
          pick_nxt   = '0;
          best_nxt   = '0;
          found_nxt  = 1'b0;
          alloc_nxt  = '0;
          taken_nxt  = '0;
          // A failed or zero-node request needs no scan.
          if (in_fail || (in_requested_count == '0)) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (avail_r[idx_r]) begin
          if (single_r) begin
            if (share_res.better) begin
              best_nxt  = share_res.share;
              pick_nxt  = idx_r;
              found_nxt = 1'b1;
            end
          end else if (taken_r < count_r) begin
            alloc_nxt[idx_r] = 1'b1;
            taken_nxt        = taken_r + CW'(1);
          end
        end
        if (idx_r == IDX_W'(ACTIVE - 1)) begin
          state_nxt = single_r ? S_WRITE : S_FINISH;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_WRITE: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        out_valid_nxt = 1'b1;
        out_fits_nxt  = fits_r;
        if (single_r) begin
          out_alloc_nxt = dlns_pkg::MASK_W'({{(ACTIVE-1){1'b0}}, 1'b1} << pick_r);
          out_node_nxt  = dlns_pkg::NODE_W'(pick_r);
          out_share_nxt = best_r;
        end else begin
          out_alloc_nxt = dlns_pkg::MASK_W'(alloc_r);
          out_node_nxt  = '0;
          out_share_nxt = '0;
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    avail_r     <= avail_nxt;
    count_r     <= count_nxt;
    data_r      <= data_nxt;
    fits_r      <= fits_nxt;
    single_r    <= single_nxt;
    idx_r       <= idx_nxt;
    pick_r      <= pick_nxt;
    best_r      <= best_nxt;
    found_r     <= found_nxt;
    alloc_r     <= alloc_nxt;
    taken_r     <= taken_nxt;
    out_fits_r  <= out_fits_nxt;
    out_alloc_r <= out_alloc_nxt;
    out_node_r  <= out_node_nxt;
    out_share_r <= out_share_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_fits           = out_fits_r;
  assign out_allocated_mask = out_alloc_r;
  assign out_chosen_node    = out_node_r;
  assign out_best_share     = out_share_r;

  // A word taken always keeps the block busy in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a word was taken");

  // The result strobe only shows once the sequencer is back at rest.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // Results of a single request never come in two consecutive cycles.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A failed request grants nothing.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fits) |-> (out_allocated_mask == '0 && out_best_share == '0))
    else $error("failed request reported an allocation");

  // Only free nodes are ever granted.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_allocated_mask & ~dlns_pkg::MASK_W'(avail_r)) == '0))
    else $error("allocation includes a node that was not free");

endmodule

// ===== hw/rtl/dlns_share_unit.sv =====
// Shared popcount and compare unit: counts the data bits a node has in common
// with the job and says whether that beats the best pick so far. Uses dlns_pkg.
module dlns_share_unit #(
  parameter int DATA_BITS = dlns_pkg::DATA_BITS_DEF
) (
  input  logic [DATA_BITS-1:0]        node_word,
  input  logic [DATA_BITS-1:0]        job_word,
  input  logic [dlns_pkg::SHARE_W-1:0] best,
  input  logic                        found,
  output dlns_pkg::share_res_t        res
);

  logic [dlns_pkg::SHARE_W-1:0] share;

  assign share = dlns_pkg::popcount(dlns_pkg::JOB_W'(node_word & job_word));

  // Only a strictly larger share displaces the current pick, so ties keep the lower node.
  assign res.share  = share;
  assign res.better = !found || (share > best);

endmodule

// ===== hw/rtl/dlns_node_store.sv =====
// Per-node data bitmap store, cleared at reset; one read port and one OR-in write port.
// Uses dlns_pkg only for its default parameter values.
module dlns_node_store #(
  parameter int NODES     = dlns_pkg::NUM_NODES_DEF,
  parameter int DATA_BITS = dlns_pkg::DATA_BITS_DEF,
  parameter int IDX_W     = $clog2(NODES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IDX_W-1:0]     rd_idx,
  output logic [DATA_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [DATA_BITS-1:0] wr_bits
);

  logic [DATA_BITS-1:0] mem_r [NODES];

  assign rd_data = mem_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) begin
        mem_r[i] <= '0;
      end
    end else if (wr_en) begin
      mem_r[wr_idx] <= mem_r[wr_idx] | wr_bits;
    end
  end

endmodule
